// ===== design/rounded_rect_gradient_span_generator_unit_assert.svh =====
// Assertion macros shared by the span generator checker.
`ifndef ROUNDED_RECT_GRADIENT_SPAN_GENERATOR_UNIT_ASSERT_SVH
`define ROUNDED_RECT_GRADIENT_SPAN_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RRG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rrg_pkg.sv =====
// Types and constants for the rounded rectangle gradient span generator.
package rrg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_X        = 3'd0,
    REG_RECT_Y        = 3'd1,
    REG_RECT_W        = 3'd2,
    REG_RECT_H        = 3'd3,
    REG_CORNER_RADIUS = 3'd4,
    REG_TOP_RGB       = 3'd5,
    REG_COLOR_BOTTOM  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [12:0] rect_x;
    logic [12:0] rect_y;
    logic [11:0] rect_w;
    logic [11:0] rect_h;
    logic [10:0] corner_radius;
    logic [23:0] top_rgb;
    logic [23:0] color_bottom;
  } cfg_t;

  typedef struct packed {
    logic [11:0] screen_row;
    logic [11:0] span_start;
    logic [12:0] span_length;
    logic [31:0] span_color;
    logic        span_visible;
  } span_t;

endpackage

// ===== design/rrg_if.sv =====
// Channel interfaces: row input, span output and register write port.
interface rrg_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] row_index;
  modport source (output valid, output row_index, input ready);
  modport sink   (input valid, input row_index, output ready);
endinterface

interface rrg_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] screen_row;
  logic [11:0] span_start;
  logic [12:0] span_length;
  logic [31:0] span_color;
  logic        span_visible;
  modport source (output valid, output screen_row, output span_start, output span_length,
                  output span_color, output span_visible, input ready);
  modport sink   (input valid, input screen_row, input span_start, input span_length,
                  input span_color, input span_visible, output ready);
endinterface

interface rrg_cfg_if import rrg_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/rrg_regs.sv =====
// Configuration register file of the span generator.
module rrg_regs import rrg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_RECT_X:        cfg_nxt.rect_x        = wr_data[12:0];
        REG_RECT_Y:        cfg_nxt.rect_y        = wr_data[12:0];
        REG_RECT_W:        cfg_nxt.rect_w        = wr_data[11:0];
        REG_RECT_H:        cfg_nxt.rect_h        = wr_data[11:0];
        REG_CORNER_RADIUS: cfg_nxt.corner_radius = wr_data[10:0];
        REG_TOP_RGB:       cfg_nxt.top_rgb       = wr_data;
        REG_COLOR_BOTTOM:  cfg_nxt.color_bottom  = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/rrg_mulcmp.sv =====
// Shared multiply and compare unit: product of two operands and a test against a bound.
module rrg_mulcmp (
  input  logic [11:0] op_a,
  input  logic [11:0] op_b,
  input  logic [23:0] bound,
  output logic [23:0] prod,
  output logic        fits
);

  assign prod = op_a * op_b;
  assign fits = (prod <= bound);

endmodule

// ===== design/rrg_core.sv =====
// Sequencer and datapath: corner inset by bit search, gradient blend by quotient search.
module rrg_core import rrg_pkg::*; #(
  parameter int SCREEN_WIDTH  = 1920,
  parameter int SCREEN_HEIGHT = 1080
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  input  logic [11:0] in_row_index,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output span_t       out_span
);

  localparam logic signed [15:0] SW_S = 16'(SCREEN_WIDTH);
  localparam logic signed [15:0] SH_S = 16'(SCREEN_HEIGHT);

  typedef enum logic [2:0] {
    S_IDLE, S_SQR_R, S_SQR_RY, S_ROOT, S_BLEND_MUL, S_BLEND_DIV, S_FINISH
  } state_t;

  state_t      state_r, state_nxt;
  logic [11:0] dy_r, dy_nxt;
  logic [21:0] rr_r, rr_nxt;
  logic [23:0] bound_r, bound_nxt;
  logic [10:0] acc_r, acc_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [10:0] dx_r, dx_nxt;
  logic [1:0]  chan_r, chan_nxt;
  logic        neg_r, neg_nxt;
  logic [23:0] col_r, col_nxt;
  logic        out_valid_r, out_valid_nxt;
  span_t       span_r, span_nxt;

  logic [11:0] mul_a, mul_b;
  logic [23:0] mul_bound, mul_prod;
  logic        mul_fits;

  rrg_mulcmp u_mul (
    .op_a  (mul_a),
    .op_b  (mul_b),
    .bound (mul_bound),
    .prod  (mul_prod),
    .fits  (mul_fits)
  );

  // Clamped radius
  logic [10:0] r_w, r_clamp;
  assign r_w     = (cfg.corner_radius > cfg.rect_w[11:1]) ? cfg.rect_w[11:1] : cfg.corner_radius;
  assign r_clamp = (r_w > cfg.rect_h[11:1]) ? cfg.rect_h[11:1] : r_w;

  // Corner band selection
  logic        top_band, bot_band, in_band, row_in;
  logic [11:0] h_minus_r;
  logic [12:0] ry_bot_w;
  logic [10:0] ry;
  assign row_in    = dy_r < cfg.rect_h;
  assign top_band  = dy_r < {1'b0, r_clamp};
  assign h_minus_r = cfg.rect_h - {1'b0, r_clamp};
  assign bot_band  = dy_r >= h_minus_r;
  assign in_band   = top_band || bot_band;
  assign ry_bot_w  = {1'b0, dy_r} + {2'b00, r_clamp} - {1'b0, cfg.rect_h};
  assign ry        = top_band ? (r_clamp - 11'd1 - dy_r[10:0]) : ry_bot_w[10:0];

  logic [10:0] trial;
  assign trial = acc_r | (11'd1 << bit_r);

  // Channel operands
  logic [7:0] ca, cb, mag, q, blended;
  always_comb begin
    case (chan_r)
      2'd2:    begin ca = cfg.top_rgb[23:16]; cb = cfg.color_bottom[23:16]; end
      2'd1:    begin ca = cfg.top_rgb[15:8];  cb = cfg.color_bottom[15:8];  end
      default: begin ca = cfg.top_rgb[7:0];   cb = cfg.color_bottom[7:0];   end
    endcase
  end
  assign mag     = (cb < ca) ? (ca - cb) : (cb - ca);
  assign q       = mul_fits ? trial[7:0] : acc_r[7:0];
  assign blended = neg_r ? (ca - q) : (ca + q);

  // Span geometry
  logic [10:0]        inset;
  logic signed [15:0] x_s, y_s, w_s, ins_s, dy_s, rx, rend, rw, yy, x0, x1, len_s;
  logic               row_vis, vis;
  assign inset = in_band ? (r_clamp - dx_r) : 11'd0;
  assign x_s   = {{3{cfg.rect_x[12]}}, cfg.rect_x};
  assign y_s   = {{3{cfg.rect_y[12]}}, cfg.rect_y};
  assign w_s   = {4'b0000, cfg.rect_w};
  assign dy_s  = {4'b0000, dy_r};
  assign ins_s = {5'b00000, inset};
  assign rx    = x_s + ins_s;
  assign rend  = x_s + w_s - ins_s;
  assign rw    = w_s - (ins_s <<< 1);
  assign yy    = y_s + dy_s;
  assign x0    = (rx < 16'sd0) ? 16'sd0 : rx;
  assign x1    = (rend > SW_S) ? SW_S : rend;
  assign len_s = x1 - x0;
  assign row_vis = row_in && (rw > 16'sd0) && (yy >= 16'sd0) && (yy < SH_S);
  assign vis     = row_vis && (x0 < x1);

  always_comb begin
    state_nxt     = state_r;
    dy_nxt        = dy_r;
    rr_nxt        = rr_r;
    bound_nxt     = bound_r;
    acc_nxt       = acc_r;
    bit_nxt       = bit_r;
    dx_nxt        = dx_r;
    chan_nxt      = chan_r;
    neg_nxt       = neg_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r && !out_ready;
    span_nxt      = span_r;
    mul_a         = {1'b0, r_clamp};
    mul_b         = {1'b0, r_clamp};
    mul_bound     = bound_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dy_nxt    = in_row_index;
          state_nxt = S_SQR_R;
        end
      end
      S_SQR_R: begin
        rr_nxt    = mul_prod[21:0];
        state_nxt = S_SQR_RY;
      end
      S_SQR_RY: begin
        mul_a     = {1'b0, ry};
        mul_b     = {1'b0, ry};
        bound_nxt = {2'b00, rr_r} - mul_prod;
        acc_nxt   = '0;
        bit_nxt   = 4'd10;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        // Keep the trial bit if its square stays within the bound
        mul_a = {1'b0, trial};
        mul_b = {1'b0, trial};
        if (mul_fits) acc_nxt = trial;
        if (bit_r == 4'd0) begin
          dx_nxt    = mul_fits ? trial : acc_r;
          chan_nxt  = 2'd2;
          state_nxt = S_BLEND_MUL;
        end else begin
          bit_nxt = bit_r - 4'd1;
        end
      end
      S_BLEND_MUL: begin
        mul_a     = {4'b0000, mag};
        mul_b     = dy_r;
        bound_nxt = mul_prod;
        neg_nxt   = cb < ca;
        acc_nxt   = '0;
        bit_nxt   = 4'd7;
        state_nxt = S_BLEND_DIV;
      end
      S_BLEND_DIV: begin
        // Largest quotient whose product with the height fits the magnitude times the row offset
        mul_a = {1'b0, trial};
        mul_b = cfg.rect_h;
        if (mul_fits) acc_nxt = trial;
        if (bit_r == 4'd0) begin
          case (chan_r)
            2'd2:    col_nxt[23:16] = blended;
            2'd1:    col_nxt[15:8]  = blended;
            default: col_nxt[7:0]   = blended;
          endcase
          if (chan_r == 2'd0) begin
            state_nxt = S_FINISH;
          end else begin
            chan_nxt  = chan_r - 2'd1;
            state_nxt = S_BLEND_MUL;
          end
        end else begin
          bit_nxt = bit_r - 4'd1;
        end
      end
      S_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          span_nxt.screen_row    = yy[11:0];
          span_nxt.span_visible  = vis;
          span_nxt.span_start    = vis ? x0[11:0] : 12'd0;
          span_nxt.span_length   = vis ? len_s[12:0] : 13'd0;
          span_nxt.span_color    = vis ? {ALPHA_OPAQUE, col_r} : 32'd0;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dy_r    <= dy_nxt;
    rr_r    <= rr_nxt;
    bound_r <= bound_nxt;
    acc_r   <= acc_nxt;
    bit_r   <= bit_nxt;
    dx_r    <= dx_nxt;
    chan_r  <= chan_nxt;
    neg_r   <= neg_nxt;
    col_r   <= col_nxt;
    span_r  <= span_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_span  = span_r;

endmodule

// ===== design/rounded_rect_gradient_span_generator_unit.sv =====
// Top level of the rounded rectangle gradient span generator.
// One row beat in gives one span beat out. A row is not accepted until the previous one has
// left the sequencer: the squares of the radius and the corner offset, 11 steps of the
// square-root bit search, one product and eight quotient bits for each of the three color
// channels, then clipping and loading the output register once it is free, and a return to
// idle. The squares, the search and the blend all run through a single shared 12x12
// multiply-compare unit. A finished span waits in the output register while the next row is
// being worked on. Registers are written through the cfg channel, which is always ready; the
// user must write them only while no row is in flight, as the block does not enforce it.
module rounded_rect_gradient_span_generator_unit import rrg_pkg::*; #(
  parameter int SCREEN_WIDTH  = 1920,
  parameter int SCREEN_HEIGHT = 1080
) (
  input  logic       clk,
  input  logic       rst_n,
  rrg_in_if.sink     in_ch,
  rrg_out_if.source  out_ch,
  rrg_cfg_if.sink    cfg_ch
);

  cfg_t  cfg;
  span_t span;

  assign cfg_ch.ready = 1'b1;

  rrg_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  rrg_core #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_ch.valid),
    .in_row_index (in_ch.row_index),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_span     (span)
  );

  assign out_ch.screen_row   = span.screen_row;
  assign out_ch.span_start   = span.span_start;
  assign out_ch.span_length  = span.span_length;
  assign out_ch.span_color   = span.span_color;
  assign out_ch.span_visible = span.span_visible;

endmodule

// ===== design/rrg_checker.sv =====
// Port-level checker for the span generator, bound to the top level.
`include "rounded_rect_gradient_span_generator_unit_assert.svh"

module rrg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] span_start,
  input logic [12:0] span_length,
  input logic [31:0] span_color,
  input logic        span_visible
);

  `RRG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "span beat dropped while stalled")
  `RRG_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "row accepted while busy")
  `RRG_ASSERT_IMP(a_hidden_zero, clk, rst_n, out_valid && !span_visible, (span_start == 12'd0) && (span_length == 13'd0) && (span_color == 32'd0), "hidden span carries data")
  `RRG_ASSERT_IMP(a_visible_span, clk, rst_n, out_valid && span_visible, (span_color[31:24] == 8'hFF) && (span_length != 13'd0), "visible span malformed")

endmodule

bind rounded_rect_gradient_span_generator_unit rrg_checker u_rrg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .span_start   (out_ch.span_start),
  .span_length  (out_ch.span_length),
  .span_color   (out_ch.span_color),
  .span_visible (out_ch.span_visible)
);
